// ===== rtl/sroc_pkg.sv =====
// shared constants and types for the segment raster overlap counter
`timescale 1ns / 1ps
`default_nettype none

package sroc_pkg;

	// coordinate and result widths
	localparam int CRD_W = 10;
	localparam int CNT_W = 21;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// square grid of cells
	localparam int GRID_SIZE = 1024;
	localparam int GRID_W = $clog2(GRID_SIZE);
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(CELLS);

	// walk position: signed, wide enough for overshoot and the grid limit
	localparam int POS_W = 14;
	localparam logic signed [POS_W-1:0] GRID_LIM = POS_W'(GRID_SIZE);

	// per-cell hit count, saturating
	localparam int HIT_W = 2;
	localparam logic [HIT_W-1:0] HIT_ONE = HIT_W'(1);
	localparam logic [HIT_W-1:0] HIT_SAT = HIT_W'(2);

	typedef struct packed {
		logic [CRD_W-1:0] start_x;
		logic [CRD_W-1:0] start_y;
		logic [CRD_W-1:0] end_x;
		logic [CRD_W-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} pt_t;

	typedef struct packed {
		logic busy;
		logic clip;
	} walk_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sroc_ifs.sv =====
// valid/ready channel interfaces for segment requests and results
`timescale 1ns / 1ps
`default_nettype none

interface sroc_seg_if import sroc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CRD_W-1:0] start_x;
	logic [CRD_W-1:0] start_y;
	logic [CRD_W-1:0] end_x;
	logic [CRD_W-1:0] end_y;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, output ready);
endinterface

interface sroc_res_if import sroc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] overlap_count;
	logic             clipped;

	modport source (output valid, output overlap_count, output clipped, input ready);
	modport sink (input valid, input overlap_count, input clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/segment_raster_overlap_count_top.sv =====
// top level: segment walker, hit-count store and overlap counter
// after reset the store is swept to zero, one cell a cycle, all GRID_SIZE^2 cells
// (1048576 at 1024) with ready low; the running overlap count resets to zero
// a segment is walked point by point, one store access per point; the result
// sits in an output register and ready returns as it is registered, so a new
// request is taken only once the result of the last one is in that register
`timescale 1ns / 1ps
`default_nettype none

module segment_raster_overlap_count_top import sroc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sroc_seg_if.sink   seg,
	sroc_res_if.source res
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_clip_q;

	seg_t              seg_req;
	pt_t               pt;
	walk_stat_t        stat;
	logic              start;
	logic              finish;
	logic [HIT_W-1:0]  hits;
	logic              bump;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [HIT_W-1:0]  wdata;

	assign seg_req.start_x = seg.start_x;
	assign seg_req.start_y = seg.start_y;
	assign seg_req.end_x   = seg.end_x;
	assign seg_req.end_y   = seg.end_y;

	// new segment only when idle and the store is swept
	assign seg.ready = (state_q == ST_IDLE);
	assign start     = seg.valid && seg.ready;

	sroc_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.seg    (seg_req),
		.pt     (pt),
		.stat   (stat)
	);

	// hit-count store: read at s1, modify and write back at s2
	sroc_ram #(
		.WIDTH (HIT_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (pt.addr),
		.rdata (hits)
	);

	// a saturated cell is left alone; points of one segment are all distinct,
	// so the write at s2 never races the read at s1
	assign bump  = valid_s2 && (hits < HIT_SAT);
	assign we    = (state_q == ST_CLEAR) || bump;
	assign waddr = (state_q == ST_CLEAR) ? clr_q : addr_s2;
	assign wdata = (state_q == ST_CLEAR) ? '0 : hits + HIT_W'(1);

	// done once the walker and both store stages are empty and the
	// output register is free
	assign finish = (state_q == ST_WALK) && !stat.busy && !pt.valid && !valid_s2
		&& (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			valid_s2    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s2 <= pt.valid;
			if (bump && (hits == HIT_ONE) && (cnt_q != COUNT_MAX)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			// a new result replaces one taken in the same cycle
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s2 <= pt.addr;
		if (finish) begin
			out_cnt_q  <= cnt_q;
			out_clip_q <= stat.clip;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.overlap_count = out_cnt_q;
	assign res.clipped       = out_clip_q;

endmodule

`default_nettype wire

// ===== rtl/sroc_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sroc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/sroc_walk.sv =====
// point walker: steps along a segment and emits in-grid cell addresses
`timescale 1ns / 1ps
`default_nettype none

module sroc_walk import sroc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire seg_t       seg,
	output pt_t             pt,
	output walk_stat_t      stat
);

	logic                    busy_q;
	logic                    clip_q;
	logic                    pt_valid_s1;
	logic [ADDR_W-1:0]       pt_addr_s1;
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	logic signed [1:0]       xs_q;
	logic signed [1:0]       ys_q;
	logic [CRD_W-1:0]        left_q;

	logic signed [CRD_W:0]   dx;
	logic signed [CRD_W:0]   dy;
	logic [CRD_W-1:0]        adx;
	logic [CRD_W-1:0]        ady;
	logic                    in_grid;
	logic [ADDR_W-1:0]       cell_addr;

	always_comb begin
		dx = $signed({1'b0, seg.end_x}) - $signed({1'b0, seg.start_x});
		dy = $signed({1'b0, seg.end_y}) - $signed({1'b0, seg.start_y});
		adx = dx[CRD_W] ? CRD_W'(-dx) : CRD_W'(dx);
		ady = dy[CRD_W] ? CRD_W'(-dy) : CRD_W'(dy);
		in_grid = !x_q[POS_W-1] && !y_q[POS_W-1] && (x_q < GRID_LIM) && (y_q < GRID_LIM);
		cell_addr = ADDR_W'(y_q[GRID_W-1:0]) * ADDR_W'(GRID_SIZE) + ADDR_W'(x_q[GRID_W-1:0]);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			clip_q      <= 1'b0;
			pt_valid_s1 <= 1'b0;
		end else if (start) begin
			busy_q      <= 1'b1;
			clip_q      <= 1'b0;
			pt_valid_s1 <= 1'b0;
		end else if (busy_q) begin
			pt_valid_s1 <= in_grid;
			clip_q      <= clip_q | !in_grid;
			if (left_q == '0) begin
				busy_q <= 1'b0;
			end
		end else begin
			pt_valid_s1 <= 1'b0;
		end
	end

	// walk position and step count
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed(POS_W'(seg.start_x));
			y_q    <= $signed(POS_W'(seg.start_y));
			xs_q   <= (dx == '0) ? 2'sb00 : (dx[CRD_W] ? 2'sb11 : 2'sb01);
			ys_q   <= (dy == '0) ? 2'sb00 : (dy[CRD_W] ? 2'sb11 : 2'sb01);
			left_q <= (dx != '0) ? adx : ady;
		end else if (busy_q) begin
			pt_addr_s1 <= cell_addr;
			x_q        <= x_q + {{(POS_W-2){xs_q[1]}}, xs_q};
			y_q        <= y_q + {{(POS_W-2){ys_q[1]}}, ys_q};
			left_q     <= left_q - CRD_W'(1);
		end
	end

	assign pt.valid  = pt_valid_s1;
	assign pt.addr   = pt_addr_s1;
	assign stat.busy = busy_q;
	assign stat.clip = clip_q;

endmodule

`default_nettype wire
